// ===== src/s8h_pkg.sv =====
// Shared types and constants for the sum8 header frame receiver.
// Holds the header bytes, byte role and frame status codes, and the result record.
// Depends on nothing.
package s8h_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd121;

  localparam logic [2:0] ROLE_SKIP = 3'd0;
  localparam logic [2:0] ROLE_HDR  = 3'd1;
  localparam logic [2:0] ROLE_VER  = 3'd2;
  localparam logic [2:0] ROLE_CMD  = 3'd3;
  localparam logic [2:0] ROLE_LEN  = 3'd4;
  localparam logic [2:0] ROLE_DATA = 3'd5;
  localparam logic [2:0] ROLE_SUM  = 3'd6;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_SUM_OK  = 2'd1;
  localparam logic [1:0] ST_SUM_BAD = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_end;
    logic [1:0]  frame_status;
    logic [7:0]  frame_version;
    logic [7:0]  frame_command;
    logic [15:0] frame_length;
  } result_t;

endpackage

// ===== src/s8h_parser.sv =====
// Frame parser: phase machine, running checksum and payload counter.
// Produces one result record per accepted byte; uses s8h_pkg.
// The state advances only at an accepted request.
module s8h_parser import s8h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        abort_i,
  input  logic [15:0] max_payload_i,
  output result_t     res_o
);

  localparam logic [2:0] PH_HUNT1 = 3'd0;
  localparam logic [2:0] PH_HUNT2 = 3'd1;
  localparam logic [2:0] PH_VER   = 3'd2;
  localparam logic [2:0] PH_CMD   = 3'd3;
  localparam logic [2:0] PH_LENH  = 3'd4;
  localparam logic [2:0] PH_LENL  = 3'd5;
  localparam logic [2:0] PH_DATA  = 3'd6;
  localparam logic [2:0] PH_SUM   = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  command_q, command_d;
  logic [15:0] count_inc;

  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    length_d  = length_q;
    count_d   = count_q;
    version_d = version_q;
    command_d = command_q;
    res_o     = '0;
    if (abort_i) begin
      phase_d   = PH_HUNT1;
      sum_d     = '0;
      length_d  = '0;
      count_d   = '0;
      version_d = '0;
      command_d = '0;
    end else begin
      case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == HDR_FIRST) begin
            res_o.byte_role = ROLE_HDR;
            sum_d           = rx_byte_i;
            phase_d         = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (rx_byte_i == HDR_SECOND) begin
            res_o.byte_role = ROLE_HDR;
            sum_d           = sum_q + rx_byte_i;
            phase_d         = PH_VER;
          end else if (rx_byte_i == HDR_FIRST) begin
            res_o.byte_role = ROLE_HDR;
            sum_d           = rx_byte_i;
          end else begin
            phase_d   = PH_HUNT1;
            sum_d     = '0;
            length_d  = '0;
            count_d   = '0;
            version_d = '0;
            command_d = '0;
          end
        end
        PH_VER: begin
          res_o.byte_role = ROLE_VER;
          version_d       = rx_byte_i;
          sum_d           = sum_q + rx_byte_i;
          phase_d         = PH_CMD;
        end
        PH_CMD: begin
          res_o.byte_role = ROLE_CMD;
          command_d       = rx_byte_i;
          sum_d           = sum_q + rx_byte_i;
          phase_d         = PH_LENH;
        end
        PH_LENH: begin
          res_o.byte_role = ROLE_LEN;
          length_d        = {rx_byte_i, 8'h00};
          sum_d           = sum_q + rx_byte_i;
          phase_d         = PH_LENL;
        end
        PH_LENL: begin
          res_o.byte_role = ROLE_LEN;
          length_d        = {length_q[15:8], rx_byte_i};
          sum_d           = sum_q + rx_byte_i;
          count_d         = '0;
          if ({length_q[15:8], rx_byte_i} > max_payload_i) begin
            res_o.frame_end    = 1'b1;
            res_o.frame_status = ST_TOO_LONG;
            phase_d            = PH_HUNT1;
          end else if ({length_q[15:8], rx_byte_i} == 16'd0) begin
            phase_d = PH_SUM;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          res_o.byte_role     = ROLE_DATA;
          res_o.payload_byte  = rx_byte_i;
          res_o.payload_index = count_q;
          sum_d               = sum_q + rx_byte_i;
          count_d             = count_inc;
          if (count_inc >= length_q) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          res_o.byte_role    = ROLE_SUM;
          res_o.frame_end    = 1'b1;
          res_o.frame_status = (sum_q == rx_byte_i) ? ST_SUM_OK : ST_SUM_BAD;
          phase_d            = PH_HUNT1;
        end
        default: begin
          phase_d = PH_HUNT1;
        end
      endcase
      if (res_o.frame_end) begin
        res_o.frame_version = version_d;
        res_o.frame_command = command_d;
        res_o.frame_length  = length_d;
        sum_d               = '0;
        count_d             = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT1;
      sum_q     <= '0;
      length_q  <= '0;
      count_q   <= '0;
      version_q <= '0;
      command_q <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      sum_q     <= sum_d;
      length_q  <= length_d;
      count_q   <= count_d;
      version_q <= version_d;
      command_q <= command_d;
    end
  end

  // An accepted abort request leaves the parser hunting with a cleared sum.
  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && abort_i |=> phase_q == PH_HUNT1 && sum_q == 8'd0)
    else $error("abort did not restart the hunt");

  // While payload bytes are expected, the count stays below the declared length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> count_q < length_q)
    else $error("payload count ran past the declared length");

  // A frame ends only on a length byte or on the checksum byte.
  a_end_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.frame_end |-> res_o.byte_role == ROLE_LEN || res_o.byte_role == ROLE_SUM)
    else $error("frame ended on an unexpected byte");

endmodule

// ===== src/s8h_out_buf.sv =====
// Output register with a skid stage for the result channel.
// Holds up to two result records so the input side keeps flowing; uses s8h_pkg.
module s8h_out_buf import s8h_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  result_t in_res_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_res_o
);

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_res_q;
  result_t skid_res_q;
  logic    accept;
  logic    out_free;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_res_q <= skid_res_q;
      end else if (accept) begin
        out_res_q <= in_res_i;
      end
    end else if (accept) begin
      skid_res_q <= in_res_i;
    end
  end

  // The skid stage is only occupied behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result with an empty output register");

  // A request taken while the output waits lands in the skid stage.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && out_valid_q && out_stall_i |=> skid_valid_q)
    else $error("request lost while the output was stalled");

endmodule

// ===== src/sum8_header_frame_receiver.sv =====
// Top level of the sum8 header frame receiver.
// Connects the configuration register, s8h_parser and s8h_out_buf; uses s8h_pkg.
//
// The receiver takes one serial byte per clock cycle while in_stall_o is low
// and returns one result per byte, registered in the output buffer. All parsing
// for a byte, including the 8-bit checksum add and the length compare, is
// combinational in the parser, whose state registers advance on each accepted
// request. Results pass through an output register backed by one skid entry, so
// the input keeps flowing while the consumer stalls and the skid entry is free;
// the input stalls only when both entries hold results. The max_payload
// register accepts a write in every cycle and resets to 121.
module sum8_header_frame_receiver import s8h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        abort_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  byte_role_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic        frame_end_o,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  frame_version_o,
  output logic [7:0]  frame_command_o,
  output logic [15:0] frame_length_o
);

  logic [15:0] max_payload_q;
  logic        accept;
  result_t     parse_res;
  result_t     out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid_i) begin
      max_payload_q <= cfg_data_i;
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  s8h_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .abort_i       (abort_i),
    .max_payload_i (max_payload_q),
    .res_o         (parse_res)
  );

  s8h_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_res_i    (parse_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign byte_role_o     = out_res.byte_role;
  assign payload_byte_o  = out_res.payload_byte;
  assign payload_index_o = out_res.payload_index;
  assign frame_end_o     = out_res.frame_end;
  assign frame_status_o  = out_res.frame_status;
  assign frame_version_o = out_res.frame_version;
  assign frame_command_o = out_res.frame_command;
  assign frame_length_o  = out_res.frame_length;

endmodule

// ===== sim/sum8_header_frame_receiver_test.sv =====
// Self-checking testbench for sum8_header_frame_receiver.
// Drives directed and random byte streams with random idling on both sides and checks every
// result against an in-bench parser or a directed row; depends on s8h_pkg and the RTL only.
`timescale 1ns / 1ps

module sum8_header_frame_receiver_test import s8h_pkg::*;;

  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_VERSION, TAKE_COMMAND,
    TAKE_LEN_HI, TAKE_LEN_LO, TAKE_PAYLOAD, TAKE_CHECKSUM
  } rx_phase_e;

  typedef struct {
    logic [7:0] rx_byte;
    logic       abort;
    bit         typed;
    result_t    want;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        abort_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  byte_role_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] payload_index_o;
  logic        frame_end_o;
  logic [1:0]  frame_status_o;
  logic [7:0]  frame_version_o;
  logic [7:0]  frame_command_o;
  logic [15:0] frame_length_o;

  rx_phase_e   rx_phase;
  logic [7:0]  frame_sum;
  logic [15:0] length_field;
  logic [15:0] payload_seen;
  logic [7:0]  version_held;
  logic [7:0]  command_held;
  logic [15:0] max_payload_model;

  result_t       expected_results[$];
  directed_row_t directed_rows[$];

  bit idle_enable;
  int stall_left;
  int errors;
  int cycle_count;
  int items_sent;
  int results_checked;
  int frames_ok;
  int frames_bad;
  int frames_long;

  sum8_header_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .abort_i         (abort_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_role_o     (byte_role_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .frame_end_o     (frame_end_o),
    .frame_status_o  (frame_status_o),
    .frame_version_o (frame_version_o),
    .frame_command_o (frame_command_o),
    .frame_length_o  (frame_length_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic void clear_frame_model();
    rx_phase     = HUNT_FIRST;
    frame_sum    = '0;
    length_field = '0;
    payload_seen = '0;
    version_held = '0;
    command_held = '0;
  endfunction

  function automatic result_t make_result(logic [2:0] role, logic fend, logic [1:0] status,
                                          logic [7:0] ver, logic [7:0] cmd, logic [15:0] len);
    result_t r;
    r = '0;
    r.byte_role     = role;
    r.frame_end     = fend;
    r.frame_status  = status;
    r.frame_version = ver;
    r.frame_command = cmd;
    r.frame_length  = len;
    return r;
  endfunction

  function automatic result_t predict_frame_result(logic [7:0] b, logic ab);
    result_t r;
    r = '0;
    if (ab) begin
      clear_frame_model();
    end else begin
      case (rx_phase)
        HUNT_FIRST: begin
          if (b == HDR_FIRST) begin
            r.byte_role = ROLE_HDR;
            frame_sum   = b;
            rx_phase    = HUNT_SECOND;
          end
        end
        HUNT_SECOND: begin
          if (b == HDR_SECOND) begin
            r.byte_role = ROLE_HDR;
            frame_sum   = frame_sum + b;
            rx_phase    = TAKE_VERSION;
          end else if (b == HDR_FIRST) begin
            r.byte_role = ROLE_HDR;
            frame_sum   = b;
          end else begin
            clear_frame_model();
          end
        end
        TAKE_VERSION: begin
          r.byte_role  = ROLE_VER;
          version_held = b;
          frame_sum    = frame_sum + b;
          rx_phase     = TAKE_COMMAND;
        end
        TAKE_COMMAND: begin
          r.byte_role  = ROLE_CMD;
          command_held = b;
          frame_sum    = frame_sum + b;
          rx_phase     = TAKE_LEN_HI;
        end
        TAKE_LEN_HI: begin
          r.byte_role  = ROLE_LEN;
          length_field = {b, 8'h00};
          frame_sum    = frame_sum + b;
          rx_phase     = TAKE_LEN_LO;
        end
        TAKE_LEN_LO: begin
          r.byte_role  = ROLE_LEN;
          length_field = length_field | {8'h00, b};
          frame_sum    = frame_sum + b;
          payload_seen = '0;
          if (length_field > max_payload_model) begin
            r.frame_end    = 1'b1;
            r.frame_status = ST_TOO_LONG;
            rx_phase       = HUNT_FIRST;
          end else if (length_field == 16'd0) begin
            rx_phase = TAKE_CHECKSUM;
          end else begin
            rx_phase = TAKE_PAYLOAD;
          end
        end
        TAKE_PAYLOAD: begin
          r.byte_role     = ROLE_DATA;
          r.payload_byte  = b;
          r.payload_index = payload_seen;
          frame_sum       = frame_sum + b;
          payload_seen    = payload_seen + 16'd1;
          if (payload_seen >= length_field) rx_phase = TAKE_CHECKSUM;
        end
        default: begin
          r.byte_role    = ROLE_SUM;
          r.frame_end    = 1'b1;
          r.frame_status = (frame_sum == b) ? ST_SUM_OK : ST_SUM_BAD;
          rx_phase       = HUNT_FIRST;
        end
      endcase
    end
    if (r.frame_end) begin
      r.frame_version = version_held;
      r.frame_command = command_held;
      r.frame_length  = length_field;
      frame_sum       = '0;
      payload_seen    = '0;
    end
    return r;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Holds one request until it is taken; an optional idle gap comes first.
  task automatic push_byte(logic [7:0] b, logic ab, bit typed, result_t want);
    int gap;
    result_t predicted;
    gap = 0;
    if (idle_enable && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    abort_i    <= ab;
    predicted = predict_frame_result(b, ab);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_byte(logic [7:0] b, logic ab);
    push_byte(b, ab, 1'b0, '0);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_payload(logic [15:0] value);
    wait_for_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    max_payload_model = value;
  endtask

  task automatic send_noise();
    int n;
    int pick;
    n = $urandom_range(1, 6);
    repeat (n) begin
      pick = $urandom_range(0, 15);
      if (pick < 4) send_byte(HDR_FIRST, 1'b0);
      else if (pick < 6) send_byte(HDR_SECOND, 1'b0);
      else if (pick == 6) send_byte(8'($urandom), 1'b1);
      else send_byte(8'($urandom), 1'b0);
    end
  endtask

  // A mostly well-formed frame with random content; some are too long, carry a bad
  // checksum, or are cut short with or without an abort.
  task automatic send_random_frame();
    logic [7:0]  frame_bytes[$];
    logic [7:0]  sum;
    logic [15:0] len;
    int          cap;
    int          cut;
    bit          too_long;
    bit          cut_by_abort;
    too_long = (max_payload_model != 16'hFFFF) && ($urandom_range(0, 9) == 0);
    if (too_long) begin
      len = 16'($urandom_range(65535, int'(max_payload_model) + 1));
    end else begin
      cap = (max_payload_model < 16'd40) ? int'(max_payload_model) : 40;
      if ($urandom_range(0, 7) != 0 && cap > 8) cap = 8;
      len = 16'($urandom_range(cap, 0));
    end
    frame_bytes = '{HDR_FIRST, HDR_SECOND};
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    if (!too_long) begin
      repeat (int'(len)) frame_bytes.push_back(8'($urandom));
      sum = '0;
      foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
      if ($urandom_range(0, 3) == 0) sum = sum ^ 8'($urandom_range(255, 1));
      frame_bytes.push_back(sum);
    end
    cut = -1;
    cut_by_abort = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 11) == 0) cut = $urandom_range(frame_bytes.size() - 1, 1);
    foreach (frame_bytes[i]) begin
      if (i == cut) begin
        if (cut_by_abort) send_byte(8'($urandom), 1'b1);
        break;
      end
      send_byte(frame_bytes[i], 1'b0);
    end
  endtask

  task automatic run_random_traffic(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_random_frame();
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, role %0d", $time, byte_role_o);
      end else begin
        want = expected_results.pop_front();
        compare_field("byte_role", 16'(want.byte_role), 16'(byte_role_o));
        compare_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte_o));
        compare_field("payload_index", want.payload_index, payload_index_o);
        compare_field("frame_end", 16'(want.frame_end), 16'(frame_end_o));
        compare_field("frame_status", 16'(want.frame_status), 16'(frame_status_o));
        compare_field("frame_version", 16'(want.frame_version), 16'(frame_version_o));
        compare_field("frame_command", 16'(want.frame_command), 16'(frame_command_o));
        compare_field("frame_length", want.frame_length, frame_length_o);
        results_checked++;
        if (frame_end_o && frame_status_o == ST_SUM_OK) frames_ok++;
        if (frame_end_o && frame_status_o == ST_SUM_BAD) frames_bad++;
        if (frame_end_o && frame_status_o == ST_TOO_LONG) frames_long++;
      end
    end
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(5, 0);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    abort_i     = 1'b0;
    out_stall_i = 1'b0;
    stall_left  = 0;
    errors      = 0;
    cycle_count = 0;
    items_sent  = 0;
    results_checked = 0;
    frames_ok   = 0;
    frames_bad  = 0;
    frames_long = 0;
    idle_enable = 1'b1;
    clear_frame_model();
    max_payload_model = MAX_PAYLOAD_RESET;

    directed_rows.push_back('{8'h55, 1'b0, 1'b1,
                              make_result(ROLE_HDR, 1'b0, ST_NONE, 8'h00, 8'h00, 16'd0)});
    directed_rows.push_back('{8'h55, 1'b0, 1'b1,
                              make_result(ROLE_HDR, 1'b0, ST_NONE, 8'h00, 8'h00, 16'd0)});
    directed_rows.push_back('{8'h12, 1'b0, 1'b1, '0});
    directed_rows.push_back('{8'h55, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hAA, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hFE, 1'b0, 1'b1,
                              make_result(ROLE_SUM, 1'b1, ST_SUM_OK, 8'hFF, 8'h00, 16'd0)});
    directed_rows.push_back('{8'h55, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hAA, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h01, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h02, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h7A, 1'b0, 1'b1,
                              make_result(ROLE_LEN, 1'b1, ST_TOO_LONG, 8'h01, 8'h02, 16'd122)});
    directed_rows.push_back('{8'h55, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hAA, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h80, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h01, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h00, 1'b0, 1'b1,
                              make_result(ROLE_SUM, 1'b1, ST_SUM_BAD, 8'h00, 8'h80, 16'd1)});
    directed_rows.push_back('{8'h55, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hAA, 1'b1, 1'b1, '0});
    directed_rows.push_back('{8'hAA, 1'b0, 1'b1, '0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      push_byte(directed_rows[i].rx_byte, directed_rows[i].abort,
                directed_rows[i].typed, directed_rows[i].want);
    end
    run_random_traffic(250);

    write_max_payload(16'd0);
    run_random_traffic(200);

    // A frame declaring the largest length is accepted and then dropped by an abort.
    write_max_payload(16'hFFFF);
    send_byte(HDR_FIRST, 1'b0);
    send_byte(HDR_SECOND, 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (40) send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
    run_random_traffic(200);

    write_max_payload(16'hFFFE);
    run_random_traffic(200);

    write_max_payload(16'($urandom_range(20, 1)));
    run_random_traffic(250);

    write_max_payload(16'($urandom));
    run_random_traffic(250);

    idle_enable = 1'b0;
    write_max_payload(MAX_PAYLOAD_RESET);
    run_random_traffic(200);

    wait_for_drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes and checked %0d results over seven max_payload settings.",
             items_sent, results_checked);
    $display("Frames ended: %0d checksum ok, %0d checksum bad, %0d too long.",
             frames_ok, frames_bad, frames_long);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
